// ===== hw/rtl/mdqo_pkg.sv =====
// Package with the types, constants and helpers shared by the message deque.
`timescale 1ns / 1ps

package mdqo_pkg;

	localparam int SLOT_COUNT = 16;
	localparam int SLOT_BYTES = 8;
	localparam int MSG_W      = 64;
	localparam int LEN_W      = 8;
	localparam int CAP_W      = 5;
	localparam int SIZE_W     = 4;
	localparam int BCNT_W     = $clog2(SLOT_BYTES + 1);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_MSG_SIZE = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		OP_SEND   = 2'd0,
		OP_URGENT = 2'd1,
		OP_RECV   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_LEN_BAD  = 3'd1,
		ST_FULL_REJ = 3'd2,
		ST_FULL_OVR = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef struct packed {
		op_t              operation;
		logic [MSG_W-1:0] message_in;
		logic [LEN_W-1:0] request_length;
		logic             overwrite_when_full;
	} req_t;

	typedef struct packed {
		status_t          status;
		logic [MSG_W-1:0] message_out;
		logic [CAP_W-1:0] stored_count;
		logic [CAP_W-1:0] free_space;
	} rsp_t;

	// Command broadcast to every cell of the ring.
	typedef struct packed {
		logic             tok_clear;
		logic             head_inc;
		logic             head_dec;
		logic             tail_inc;
		logic             wr_tail;
		logic             wr_head;
		logic [MSG_W-1:0] wr_mask;
		logic [MSG_W-1:0] wr_data;
	} cell_ctrl_t;

	// Per-cell view of its ring neighbors and its place in the ring.
	typedef struct packed {
		logic first;
		logic active;
		logic head_prev;
		logic head_next;
		logic tail_prev;
	} cell_nbr_t;

	function automatic logic [MSG_W-1:0] byte_mask(input logic [BCNT_W-1:0] n);
		logic [MSG_W-1:0] m;
		m = '0;
		for (int b = 0; b < SLOT_BYTES; b++) begin
			m[b*8 +: 8] = {8{n > BCNT_W'(b)}};
		end
		return m;
	endfunction

endpackage

// ===== hw/rtl/mdqo_cell.sv =====
// One message slot of the ring, holding its bytes and its head and tail tokens.
`timescale 1ns / 1ps

module mdqo_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mdqo_pkg::cell_ctrl_t     ctrl,
	input  mdqo_pkg::cell_nbr_t      nbr,
	output logic                     head_tok,
	output logic                     tail_tok,
	output logic [mdqo_pkg::MSG_W-1:0] rd_data
);
	import mdqo_pkg::*;

	logic             head_q;
	logic             tail_q;
	logic [MSG_W-1:0] data_q;
	logic             head_d;
	logic             tail_d;
	logic             wen;

	always_comb begin
		if (ctrl.tok_clear) begin
			head_d = nbr.first;
			tail_d = nbr.first;
		end else begin
			if (ctrl.head_inc) begin
				head_d = nbr.head_prev & nbr.active;
			end else if (ctrl.head_dec) begin
				head_d = nbr.head_next & nbr.active;
			end else begin
				head_d = head_q;
			end
			if (ctrl.tail_inc) begin
				tail_d = nbr.tail_prev & nbr.active;
			end else begin
				tail_d = tail_q;
			end
		end
	end

	assign wen = (ctrl.wr_tail & tail_q) | (ctrl.wr_head & head_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= nbr.first;
			tail_q <= nbr.first;
			data_q <= '0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			if (wen) begin
				data_q <= (data_q & ~ctrl.wr_mask) | (ctrl.wr_data & ctrl.wr_mask);
			end
		end
	end

	assign head_tok = head_q;
	assign tail_tok = tail_q;
	assign rd_data  = head_q ? data_q : '0;

endmodule

// ===== hw/rtl/message_deque_with_overwrite_unit.sv =====
// Top level of the message deque: a ring of slot cells with head and tail tokens.
//
//  Channel | Direction | Handshake                | Payload
//  req     | in        | req_valid / req_stall    | operation, message, length, overwrite
//  rsp     | out       | rsp_valid / rsp_stall    | status, message, count, free space
//  cfg     | in        | cfg_valid / cfg_ready    | register index and write data
//
// Each transaction is decided in the cycle it is accepted, one per cycle while req_stall is low.
// Its result appears on rsp in the following cycle, from the output register.
// A new transaction is taken while the output register is empty or being drained.
// Reset places both tokens at the first cell and clears every slot.
// The head and tail tokens move at most one cell per transaction along the ring.
`timescale 1ns / 1ps

module message_deque_with_overwrite_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  mdqo_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output mdqo_pkg::rsp_t                    rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mdqo_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mdqo_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mdqo_pkg::*;

	logic [CAP_W-1:0]  cap_q;
	logic [SIZE_W-1:0] size_q;
	logic [CAP_W-1:0]  count_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [CAP_W-1:0]  cap_use;
	logic [SIZE_W-1:0] size_use;
	logic              accept;
	logic              cfg_we;
	logic              cfg_clear;
	logic              full;
	logic              ovr;
	logic [BCNT_W-1:0] rd_bytes;
	logic [CAP_W-1:0]  count_d;
	status_t           status_d;
	logic [MSG_W-1:0]  rx_d;
	cell_ctrl_t        cmd;
	cell_ctrl_t        ctrl;

	logic [SLOT_COUNT-1:0] head_tok;
	logic [SLOT_COUNT-1:0] tail_tok;
	logic [SLOT_COUNT-1:0] is_last;
	logic [SLOT_COUNT-1:0] active;
	logic [MSG_W-1:0]      rd_cell [SLOT_COUNT];
	logic [MSG_W-1:0]      rd_all;
	logic                  head_last;
	logic                  tail_last;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;
	assign cfg_clear = cfg_we & (cfg_index inside {CFG_CAPACITY, CFG_MSG_SIZE});
	assign req_stall = rsp_valid_q & rsp_stall;
	assign accept    = req_valid & ~req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		if (cap_q == '0) begin
			cap_use = CAP_W'(1);
		end else if (cap_q > CAP_W'(SLOT_COUNT)) begin
			cap_use = CAP_W'(SLOT_COUNT);
		end else begin
			cap_use = cap_q;
		end
		if (size_q > SIZE_W'(SLOT_BYTES)) begin
			size_use = SIZE_W'(SLOT_BYTES);
		end else begin
			size_use = size_q;
		end
	end

	always_comb begin
		head_last = 1'b0;
		tail_last = 1'b0;
		rd_all    = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			is_last[i] = (CAP_W'(i) == cap_use - CAP_W'(1));
			active[i]  = (CAP_W'(i) < cap_use);
			head_last  = head_last | (head_tok[i] & is_last[i]);
			tail_last  = tail_last | (tail_tok[i] & is_last[i]);
			rd_all     = rd_all | rd_cell[i];
		end
	end

	for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
		cell_nbr_t nbr;

		always_comb begin
			nbr.first  = (g == 0);
			nbr.active = active[g];
			if (g == 0) begin
				nbr.head_prev = head_last;
				nbr.tail_prev = tail_last;
			end else begin
				nbr.head_prev = head_tok[(g + SLOT_COUNT - 1) % SLOT_COUNT];
				nbr.tail_prev = tail_tok[(g + SLOT_COUNT - 1) % SLOT_COUNT];
			end
			if (is_last[g]) begin
				nbr.head_next = head_tok[0];
			end else if (g == SLOT_COUNT - 1) begin
				nbr.head_next = 1'b0;
			end else begin
				nbr.head_next = head_tok[(g + 1) % SLOT_COUNT];
			end
		end

		mdqo_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.nbr      (nbr),
			.head_tok (head_tok[g]),
			.tail_tok (tail_tok[g]),
			.rd_data  (rd_cell[g])
		);
	end

	assign full = (count_q == cap_use);
	assign ovr  = full & req.overwrite_when_full;

	always_comb begin
		cmd          = '0;
		cmd.wr_data  = req.message_in;
		cmd.wr_mask  = byte_mask(BCNT_W'(req.request_length));
		status_d     = ST_OK;
		count_d      = count_q;
		rx_d         = '0;
		if (req.request_length > LEN_W'(SLOT_BYTES)) begin
			rd_bytes = BCNT_W'(SLOT_BYTES);
		end else begin
			rd_bytes = BCNT_W'(req.request_length);
		end
		case (req.operation)
			OP_SEND, OP_URGENT: begin
				if (req.request_length > LEN_W'(size_use)) begin
					status_d = ST_LEN_BAD;
				end else if (full && !req.overwrite_when_full) begin
					status_d = ST_FULL_REJ;
				end else begin
					status_d = ovr ? ST_FULL_OVR : ST_OK;
					count_d  = ovr ? count_q : count_q + CAP_W'(1);
					if (req.operation == OP_SEND) begin
						cmd.tail_inc = 1'b1;
						cmd.head_inc = ovr;
						cmd.wr_tail  = 1'b1;
					end else begin
						cmd.head_dec = ~ovr;
						cmd.wr_head  = 1'b1;
					end
				end
			end
			OP_RECV: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					rx_d         = rd_all & byte_mask(rd_bytes);
					count_d      = count_q - CAP_W'(1);
					cmd.head_inc = 1'b1;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_comb begin
		ctrl = accept ? cmd : '0;
		ctrl.tok_clear = cfg_clear;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_W'(SLOT_COUNT);
			size_q      <= SIZE_W'(SLOT_BYTES);
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_CAPACITY) begin
					cap_q <= cfg_data[CAP_W-1:0];
				end else if (cfg_index == CFG_MSG_SIZE) begin
					size_q <= cfg_data[SIZE_W-1:0];
				end
			end
			if (cfg_clear) begin
				count_q <= '0;
			end else if (accept) begin
				count_q <= count_d;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status       <= status_d;
			rsp_q.message_out  <= rx_d;
			rsp_q.stored_count <= count_d;
			rsp_q.free_space   <= cap_use - count_d;
		end
	end

	// The ring always has exactly one head and one tail position.
	a_head_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(head_tok))
		else $error("head token is not one-hot");

	a_tail_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(tail_tok))
		else $error("tail token is not one-hot");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cap_use)
		else $error("stored count exceeds capacity");

	a_empty_tokens: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_tok == tail_tok))
		else $error("empty queue with head and tail apart");

endmodule

// ===== tb/message_deque_with_overwrite_unit_test.sv =====
// Self-checking testbench of the message deque, with a predictor, driver and monitor.
`timescale 1ns / 1ps

module message_deque_with_overwrite_unit_test;
	import mdqo_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(2);
	localparam int PHASES = 11;
	localparam int PHASE_ITEMS = 86;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predicted state of the ring and its registers.
	logic [MSG_W-1:0] ring_bytes [SLOT_COUNT];
	int unsigned ring_head = 0;
	int unsigned ring_tail = 0;
	int unsigned ring_held = 0;
	logic [CAP_W-1:0] cfg_capacity = CAP_W'(SLOT_COUNT);
	logic [SIZE_W-1:0] cfg_msg_size = SIZE_W'(SLOT_BYTES);

	req_t req_backlog [$];
	rsp_t rsp_due [$];
	rsp_t due_rsp;
	int unsigned mismatches = 0;
	int unsigned accepted_total = 0;
	int unsigned rsp_seen = 0;
	int unsigned send_gap = 0;
	int unsigned stall_gap = 0;
	int unsigned hold_left = 0;
	int unsigned long_holds = 0;
	int unsigned idle_odds = 4;

	message_deque_with_overwrite_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		for (int s = 0; s < SLOT_COUNT; s++) begin
			ring_bytes[s] = '0;
		end
	end

	function automatic logic [MSG_W-1:0] lane_mask(input int unsigned n);
		logic [MSG_W-1:0] m;
		m = '0;
		for (int b = 0; b < SLOT_BYTES; b++) begin
			if (b < n) begin
				m[b*8 +: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

	function automatic int unsigned size_limit();
		return (cfg_msg_size > SLOT_BYTES) ? SLOT_BYTES : cfg_msg_size;
	endfunction

	function automatic rsp_t predict_deque_rsp(input req_t r);
		rsp_t e;
		int unsigned cap;
		int unsigned len;
		int unsigned slot;
		logic [MSG_W-1:0] m;
		cap = (cfg_capacity == 0) ? 1 : ((cfg_capacity > SLOT_COUNT) ? SLOT_COUNT : cfg_capacity);
		len = r.request_length;
		e.status = ST_OK;
		e.message_out = '0;
		ring_head = ring_head % cap;
		ring_tail = ring_tail % cap;
		if (ring_held > cap) begin
			ring_held = cap;
		end
		case (r.operation)
			OP_SEND, OP_URGENT: begin
				if (len > size_limit()) begin
					e.status = ST_LEN_BAD;
				end else if (ring_held == cap && !r.overwrite_when_full) begin
					e.status = ST_FULL_REJ;
				end else begin
					m = lane_mask(len);
					if (ring_held == cap) begin
						ring_head = (ring_head + 1) % cap;
						ring_held--;
						e.status = ST_FULL_OVR;
					end
					if (r.operation == OP_SEND) begin
						slot = ring_tail;
						ring_tail = (ring_tail + 1) % cap;
					end else begin
						ring_head = (ring_head + cap - 1) % cap;
						slot = ring_head;
					end
					ring_bytes[slot] = (ring_bytes[slot] & ~m) | (r.message_in & m);
					ring_held++;
				end
			end
			OP_RECV: begin
				if (ring_held == 0) begin
					e.status = ST_EMPTY;
				end else begin
					e.message_out = ring_bytes[ring_head]
						& lane_mask((len > SLOT_BYTES) ? SLOT_BYTES : len);
					ring_head = (ring_head + 1) % cap;
					ring_held--;
				end
			end
			default: ;
		endcase
		e.stored_count = CAP_W'(ring_held);
		e.free_space = CAP_W'(cap - ring_held);
		return e;
	endfunction

	function automatic req_t make_item(input int unsigned send_pct);
		req_t r;
		int unsigned roll;
		r.message_in = {$urandom, $urandom};
		r.overwrite_when_full = 1'($urandom_range(0, 1));
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			r.operation = op_t'(2'd3);
		end else if (roll < 4 + send_pct) begin
			if ($urandom_range(0, 3) == 0) begin
				r.operation = OP_URGENT;
			end else begin
				r.operation = OP_SEND;
			end
		end else begin
			r.operation = OP_RECV;
		end
		if ($urandom_range(0, 9) == 0) begin
			r.request_length = LEN_W'($urandom_range(0, 255));
		end else if (r.operation == OP_RECV) begin
			r.request_length = LEN_W'($urandom_range(0, SLOT_BYTES));
		end else begin
			r.request_length = LEN_W'($urandom_range(0, size_limit()));
		end
		return r;
	endfunction

	task automatic add_item(input op_t op, input logic [MSG_W-1:0] msg,
			input logic [LEN_W-1:0] len, input logic ovr);
		req_t r;
		r.operation = op;
		r.message_in = msg;
		r.request_length = len;
		r.overwrite_when_full = ovr;
		req_backlog.push_back(r);
	endtask

	task automatic flag_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic wait_idle();
		while (req_backlog.size() != 0 || req_valid || rsp_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		do begin
			@(posedge clk);
		end while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Driver: applies register writes to the predictor and feeds request transactions.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_CAPACITY) begin
					cfg_capacity = cfg_data;
					ring_head = 0;
					ring_tail = 0;
					ring_held = 0;
				end else if (cfg_index == CFG_MSG_SIZE) begin
					cfg_msg_size = cfg_data[SIZE_W-1:0];
					ring_head = 0;
					ring_tail = 0;
					ring_held = 0;
				end
			end
			if (req_valid && !req_stall) begin
				rsp_due.push_back(predict_deque_rsp(req));
				accepted_total++;
			end
			if (!req_valid || !req_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					req_valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					req <= req_backlog.pop_front();
					req_valid <= 1'b1;
					if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
						send_gap = $urandom_range(1, 3);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each response transaction and drives the stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				rsp_seen++;
				if (rsp_due.size() == 0) begin
					flag_mismatch($sformatf("response %0d arrived with none expected", rsp_seen));
				end else begin
					due_rsp = rsp_due.pop_front();
					if (rsp.status !== due_rsp.status) begin
						flag_mismatch($sformatf("response %0d status %0d, expected %0d",
							rsp_seen, rsp.status, due_rsp.status));
					end
					if (rsp.message_out !== due_rsp.message_out) begin
						flag_mismatch($sformatf("response %0d message %h, expected %h",
							rsp_seen, rsp.message_out, due_rsp.message_out));
					end
					if (rsp.stored_count !== due_rsp.stored_count) begin
						flag_mismatch($sformatf("response %0d count %0d, expected %0d",
							rsp_seen, rsp.stored_count, due_rsp.stored_count));
					end
					if (rsp.free_space !== due_rsp.free_space) begin
						flag_mismatch($sformatf("response %0d free %0d, expected %0d",
							rsp_seen, rsp.free_space, due_rsp.free_space));
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else if ((long_holds == 0 && accepted_total >= 300)
					|| (long_holds == 1 && accepted_total >= 700)) begin
				long_holds++;
				hold_left = 50;
				rsp_stall <= 1'b1;
			end else if (stall_gap != 0) begin
				stall_gap--;
				rsp_stall <= 1'b1;
			end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				stall_gap = $urandom_range(0, 2);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		int unsigned caps [PHASES] = '{1, 0, 16, 31, 17, 4, 0, 2, 8, 3, 16};
		int unsigned sizes [PHASES] = '{8, 3, 8, 0, 15, 1, 0, 20, 5, 8, 2};
		int unsigned send_pct;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		add_item(OP_RECV, 64'h0, 8'd8, 1'b0);
		add_item(OP_SEND, 64'hFFFF_FFFF_FFFF_FFFF, 8'd8, 1'b0);
		add_item(OP_SEND, 64'hFFFF_FFFF_FFFF_FFFF, 8'd9, 1'b1);
		add_item(OP_SEND, 64'h0, 8'd255, 1'b0);
		add_item(OP_SEND, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 1'b0);
		add_item(OP_URGENT, 64'h0123_4567_89AB_CDEF, 8'd3, 1'b0);
		add_item(op_t'(2'd3), 64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 1'b1);
		add_item(OP_RECV, 64'h0, 8'd255, 1'b0);
		add_item(OP_RECV, 64'h0, 8'd0, 1'b0);
		add_item(OP_RECV, 64'h0, 8'd8, 1'b0);
		add_item(OP_RECV, 64'h0, 8'd8, 1'b0);
		wait_idle();
		write_reg(CFG_CAPACITY, 2);
		add_item(OP_SEND, 64'hA1A2_A3A4_A5A6_A7A8, 8'd8, 1'b0);
		add_item(OP_SEND, 64'hB1B2_B3B4_B5B6_B7B8, 8'd8, 1'b0);
		add_item(OP_SEND, 64'hC1C2_C3C4_C5C6_C7C8, 8'd4, 1'b0);
		add_item(OP_SEND, 64'hC1C2_C3C4_C5C6_C7C8, 8'd8, 1'b1);
		add_item(OP_URGENT, 64'hD1D2_D3D4_D5D6_D7D8, 8'd8, 1'b0);
		add_item(OP_URGENT, 64'hD1D2_D3D4_D5D6_D7D8, 8'd8, 1'b1);
		add_item(OP_RECV, 64'h0, 8'd8, 1'b0);
		add_item(OP_RECV, 64'h0, 8'd8, 1'b0);
		add_item(OP_RECV, 64'h0, 8'd8, 1'b0);
		wait_idle();
		write_reg(CFG_MSG_SIZE, 0);
		add_item(OP_SEND, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 1'b0);
		add_item(OP_SEND, 64'hFFFF_FFFF_FFFF_FFFF, 8'd1, 1'b0);
		add_item(OP_RECV, 64'h0, 8'd8, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			// The seventh phase writes an unused index, which must leave the ring as it is.
			if (p == 6) begin
				write_reg(CFG_SPARE, 31);
			end else begin
				write_reg(CFG_CAPACITY, caps[p]);
				write_reg(CFG_MSG_SIZE, sizes[p]);
			end
			idle_odds = (p == PHASES - 1) ? 0 : $urandom_range(0, 2) * 4;
			send_pct = $urandom_range(35, 65);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == PHASE_ITEMS / 2) begin
					wait_idle();
				end
				req_backlog.push_back(make_item(send_pct));
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("message_deque_with_overwrite_unit_test OK");
		end else begin
			$display("message_deque_with_overwrite_unit_test NOT OK");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("message_deque_with_overwrite_unit_test NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/mdqo_pkg.sv
hw/rtl/mdqo_cell.sv
hw/rtl/message_deque_with_overwrite_unit.sv
tb/message_deque_with_overwrite_unit_test.sv
